// File: design/plcle_pkg.sv
// ----------------------------------------------------------------------------
// plcle_pkg - shared types and constants for the powerline command link engine
// Operation codes, result kinds, protocol bytes, phase enums and code tables.
// ----------------------------------------------------------------------------
package plcle_pkg;

  // operation carried in tuser of an input item
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RX   = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // result kind carried in tuser of a result item
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ECHO  = 2'd1;
  localparam logic [1:0] EV_ASYNC = 2'd2;

  // link protocol bytes
  localparam logic [7:0] BYTE_STX      = 8'h02;
  localparam logic [7:0] BYTE_ACK      = 8'h06;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_NAK      = 8'h15;
  localparam logic [7:0] BYTE_ECHO     = 8'h58;
  localparam logic [7:0] BYTE_CMD      = 8'h63;
  localparam logic [7:0] BYTE_ASYNC    = 8'h78;
  localparam logic [7:0] COUNT_OFFSET  = 8'h30;
  localparam logic [7:0] REPEAT_OFFSET = 8'h40;
  localparam logic [7:0] CODE_UNMAPPED = 8'hFF;

  typedef enum logic [3:0] {
    TX_IDLE     = 4'd0,
    TX_PREAMBLE = 4'd1,
    TX_ACKWAIT  = 4'd2,
    TX_CRWAIT   = 4'd3,
    TX_CMD      = 4'd4,
    TX_HOUSE    = 4'd5,
    TX_UNIT     = 4'd6,
    TX_FUNC     = 4'd7,
    TX_REPEAT   = 4'd8,
    TX_ECHOWAIT = 4'd9
  } tx_phase_t;

  typedef enum logic [2:0] {
    RX_IDLE   = 3'd0,
    RX_HOUSE  = 3'd1,
    RX_UNIT   = 3'd2,
    RX_CNT1   = 3'd3,
    RX_START2 = 3'd4,
    RX_HOUSE2 = 3'd5,
    RX_FUNC   = 3'd6,
    RX_CNT2   = 3'd7
  } rx_phase_t;

  // house wire code to letter 'A'..'P'
  function automatic logic [7:0] map_house(input logic [7:0] code);
    logic [7:0] letter;
    case (code)
      8'h46:   letter = 8'h41;
      8'h4E:   letter = 8'h42;
      8'h42:   letter = 8'h43;
      8'h4A:   letter = 8'h44;
      8'h41:   letter = 8'h45;
      8'h49:   letter = 8'h46;
      8'h45:   letter = 8'h47;
      8'h4D:   letter = 8'h48;
      8'h47:   letter = 8'h49;
      8'h4F:   letter = 8'h4A;
      8'h43:   letter = 8'h4B;
      8'h4B:   letter = 8'h4C;
      8'h40:   letter = 8'h4D;
      8'h48:   letter = 8'h4E;
      8'h44:   letter = 8'h4F;
      8'h4C:   letter = 8'h50;
      default: letter = CODE_UNMAPPED;
    endcase
    return letter;
  endfunction

  // unit wire code to unit number 1..16
  function automatic logic [7:0] map_unit(input logic [7:0] code);
    logic [7:0] unit;
    case (code)
      8'h4C:   unit = 8'd1;
      8'h5C:   unit = 8'd2;
      8'h44:   unit = 8'd3;
      8'h54:   unit = 8'd4;
      8'h42:   unit = 8'd5;
      8'h52:   unit = 8'd6;
      8'h4A:   unit = 8'd7;
      8'h5A:   unit = 8'd8;
      8'h4E:   unit = 8'd9;
      8'h5E:   unit = 8'd10;
      8'h46:   unit = 8'd11;
      8'h56:   unit = 8'd12;
      8'h40:   unit = 8'd13;
      8'h50:   unit = 8'd14;
      8'h48:   unit = 8'd15;
      8'h58:   unit = 8'd16;
      default: unit = CODE_UNMAPPED;
    endcase
    return unit;
  endfunction

endpackage

// File: design/powerline_command_link_engine.sv
// ----------------------------------------------------------------------------
// powerline_command_link_engine - byte handler for a powerline command link
// Runs the send handshake (STX, ACK/NAK, CR, command bytes) and parses echo
// and asynchronous reception frames, one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | direction | tuser          | tdata
//  s_axis   | in        | op             | byte_value, house_code, unit_code,
//           |           |                | function_code, repeat_count
//  m_axis   | out       | event_kind     | tx_valid, tx_byte, refused,
//           |           |                | house_letter, unit_number,
//           |           |                | received_count
//
//  One item per cycle while results are taken; each item goes from acceptance
//  to its result: an input register, then the phase logic into the result
//  register. Link state updates when an item moves into the result register.
//  rst (synchronous) returns both phase machines to idle and empties both
//  registers. A stalled result holds; input is still taken while the input
//  register is empty or moving forward.
// ----------------------------------------------------------------------------
module powerline_command_link_engine
  import plcle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_value[7:0], house_code[15:8], unit_code[23:16],
  // function_code[31:24], repeat_count[39:32]
  input  logic [39:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_valid[0], tx_byte[8:1], refused[9], house_letter[17:10],
  // unit_number[25:18], received_count[33:26], zero[39:34]
  output logic [39:0] m_axis_tdata,
  // event_kind[1:0]
  output logic [1:0]  m_axis_tuser
);

  // input register
  logic        in_valid;
  logic [39:0] in_data;
  logic [1:0]  in_op;

  // result register
  logic        out_valid;
  logic [39:0] out_data;
  logic [1:0]  out_kind;

  // link state
  tx_phase_t   tx_phase, tx_phase_next;
  rx_phase_t   rx_phase, rx_phase_next;
  logic        tx_busy, tx_busy_next;
  logic        rx_busy, rx_busy_next;
  logic        echo_frame, echo_frame_next;
  logic        tx_enabled, tx_enabled_next;
  logic [7:0]  pending_house, pending_unit, pending_func, pending_repeat;
  logic [7:0]  rcv_house, rcv_house_next;
  logic [7:0]  rcv_unit, rcv_unit_next;

  // result of the current item
  logic        res_tx_valid;
  logic [7:0]  res_tx_byte;
  logic        res_refused;
  logic [1:0]  res_kind;
  logic [7:0]  res_house, res_unit, res_count;
  logic        load_pending;
  logic        handled;

  logic        advance;
  logic [7:0]  in_byte;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_byte       = in_data[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
      in_op   <= s_axis_tuser;
    end
  end

  always_comb begin
    tx_phase_next   = tx_phase;
    rx_phase_next   = rx_phase;
    tx_busy_next    = tx_busy;
    rx_busy_next    = rx_busy;
    echo_frame_next = echo_frame;
    tx_enabled_next = tx_enabled;
    rcv_house_next  = rcv_house;
    rcv_unit_next   = rcv_unit;
    load_pending    = 1'b0;
    handled         = 1'b0;
    res_tx_valid    = 1'b0;
    res_tx_byte     = 8'h00;
    res_refused     = 1'b0;
    res_kind        = EV_NONE;
    res_house       = 8'h00;
    res_unit        = 8'h00;
    res_count       = 8'h00;

    case (in_op)
      OP_SEND: begin
        if (tx_busy || rx_busy) begin
          res_refused = 1'b1;
        end else begin
          load_pending    = 1'b1;
          tx_busy_next    = 1'b1;
          tx_phase_next   = TX_PREAMBLE;
          tx_enabled_next = 1'b1;
        end
      end
      OP_TICK: begin
        if (tx_enabled) begin
          case (tx_phase)
            TX_PREAMBLE: begin
              res_tx_valid    = 1'b1;
              res_tx_byte     = BYTE_STX;
              tx_phase_next   = TX_ACKWAIT;
              tx_enabled_next = 1'b0;
            end
            TX_CMD: begin
              res_tx_valid  = 1'b1;
              res_tx_byte   = BYTE_CMD;
              tx_phase_next = TX_HOUSE;
            end
            TX_HOUSE: begin
              res_tx_valid  = 1'b1;
              res_tx_byte   = pending_house;
              tx_phase_next = TX_UNIT;
            end
            TX_UNIT: begin
              res_tx_valid  = 1'b1;
              res_tx_byte   = pending_unit;
              tx_phase_next = TX_FUNC;
            end
            TX_FUNC: begin
              res_tx_valid  = 1'b1;
              res_tx_byte   = pending_func;
              tx_phase_next = TX_REPEAT;
            end
            TX_REPEAT: begin
              res_tx_valid    = 1'b1;
              res_tx_byte     = pending_repeat;
              tx_phase_next   = TX_ECHOWAIT;
              tx_enabled_next = 1'b0;
            end
            default: begin
              // waiting phases send nothing and stay armed
            end
          endcase
        end
      end
      OP_RX: begin
        // handshake bytes belong to the send side only while it expects them
        if (tx_busy) begin
          if (in_byte == BYTE_CR && tx_phase == TX_CRWAIT) begin
            tx_phase_next   = TX_CMD;
            tx_enabled_next = 1'b1;
            handled         = 1'b1;
          end else if (in_byte == BYTE_ACK && tx_phase == TX_ACKWAIT) begin
            tx_phase_next = TX_CRWAIT;
            handled       = 1'b1;
          end else if (in_byte == BYTE_NAK && tx_phase == TX_ACKWAIT) begin
            tx_phase_next   = TX_PREAMBLE;
            tx_enabled_next = 1'b1;
            handled         = 1'b1;
          end
        end
        // drop stray CR; everything else feeds the frame parser
        if (!handled && in_byte != BYTE_CR) begin
          case (rx_phase)
            RX_IDLE: begin
              if (in_byte == BYTE_ECHO) begin
                echo_frame_next = 1'b1;
                rx_phase_next   = RX_HOUSE;
              end else if (in_byte == BYTE_ASYNC) begin
                rx_busy_next    = 1'b1;
                echo_frame_next = 1'b0;
                rx_phase_next   = RX_HOUSE;
              end
            end
            RX_HOUSE: begin
              rcv_house_next = map_house(in_byte);
              rx_phase_next  = RX_UNIT;
            end
            RX_UNIT: begin
              rcv_unit_next = map_unit(in_byte);
              rx_phase_next = RX_CNT1;
            end
            RX_CNT1:   rx_phase_next = RX_START2;
            RX_START2: rx_phase_next = RX_HOUSE2;
            RX_HOUSE2: rx_phase_next = RX_FUNC;
            RX_FUNC:   rx_phase_next = RX_CNT2;
            RX_CNT2: begin
              if (echo_frame) begin
                tx_busy_next = 1'b0;
                res_kind     = EV_ECHO;
              end else begin
                rx_busy_next = 1'b0;
                res_kind     = EV_ASYNC;
              end
              res_house     = rcv_house;
              res_unit      = rcv_unit;
              res_count     = in_byte - COUNT_OFFSET;
              rx_phase_next = RX_IDLE;
            end
            default: rx_phase_next = RX_IDLE;
          endcase
        end
      end
      default: begin
        // unused op: no change, all-zero result
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_phase       <= TX_IDLE;
      rx_phase       <= RX_IDLE;
      tx_busy        <= 1'b0;
      rx_busy        <= 1'b0;
      echo_frame     <= 1'b0;
      tx_enabled     <= 1'b0;
      pending_house  <= 8'h00;
      pending_unit   <= 8'h00;
      pending_func   <= 8'h00;
      pending_repeat <= 8'h00;
      rcv_house      <= 8'h00;
      rcv_unit       <= 8'h00;
    end else if (advance) begin
      tx_phase   <= tx_phase_next;
      rx_phase   <= rx_phase_next;
      tx_busy    <= tx_busy_next;
      rx_busy    <= rx_busy_next;
      echo_frame <= echo_frame_next;
      tx_enabled <= tx_enabled_next;
      rcv_house  <= rcv_house_next;
      rcv_unit   <= rcv_unit_next;
      if (load_pending) begin
        pending_house  <= in_data[15:8];
        pending_unit   <= in_data[23:16];
        pending_func   <= in_data[31:24];
        pending_repeat <= in_data[39:32] + REPEAT_OFFSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= {6'd0, res_count, res_unit, res_house, res_refused,
                   res_tx_byte, res_tx_valid};
      out_kind <= res_kind;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

  // a refused request produces neither a byte nor a frame event
  a_refused_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[9] |-> !out_data[0] && out_kind == EV_NONE)
    else $error("refused result carries other activity");

  // transmitter is armed only in a phase that sends on a tick
  a_armed_phase: assert property (@(posedge clk) disable iff (rst)
    tx_enabled |-> tx_phase != TX_IDLE && tx_phase != TX_ACKWAIT &&
                   tx_phase != TX_CRWAIT && tx_phase != TX_ECHOWAIT)
    else $error("transmitter armed in a waiting phase");

  // input stalls only when a full input register faces a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && out_valid && !m_axis_tready)
    else $error("input stalled without a stalled result");

  // an accepted item reaches the result register in the next cycle when free
  a_forward: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("item did not advance to the result register");

endmodule
